@@ hw/rtl/rain_trend_slope_classifier_unit_macros.svh @@
`ifndef RAIN_TREND_SLOPE_CLASSIFIER_UNIT_MACROS_SVH
`define RAIN_TREND_SLOPE_CLASSIFIER_UNIT_MACROS_SVH

// Concurrent checks on clk, disabled while rst_n is low.
`define RTSC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define RTSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/rtsc_pkg.sv @@
`timescale 1ns / 1ps

package rtsc_pkg;

    localparam int ADC_BITS    = 10;
    localparam int LEVEL_W     = 8;
    localparam int LEVEL_CLAMP = 100;

    localparam int GSUM_W = 18;
    localparam int CNT_W  = 8;
    localparam int IDX_W  = 8;
    localparam int SY_W   = 18;
    localparam int SXY_W  = 26;
    localparam int SX_W   = 15;
    localparam int SX2_W  = 23;

    localparam int MA_W        = 26;
    localparam int MB_W        = 18;
    localparam int PROD_W      = 34;
    localparam int DEN_W       = 31;
    localparam int QW          = ADC_BITS;
    localparam int SLOPE_STEPS = 8;
    localparam int DSH_W       = DEN_W + SLOPE_STEPS - 1;
    localparam int STEP_W      = 4;

    localparam logic [ADC_BITS-1:0] ADC_MAX = '1;

    localparam logic [7:0] SPP_RESET    = 8'd4;
    localparam logic [7:0] NPTS_RESET   = 8'd10;
    localparam logic [7:0] YELLOW_RESET = 8'd25;
    localparam logic [7:0] ORANGE_RESET = 8'd50;
    localparam logic [7:0] RED_RESET    = 8'd75;

    typedef logic [9:0]         adc_reading_t;
    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [2:0]         cfg_index_t;
    typedef logic [7:0]         cfg_data_t;

    typedef enum logic [0:0] {
        OP_SAMPLE   = 1'b0,
        OP_CLASSIFY = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        WARN_NONE   = 2'd0,
        WARN_YELLOW = 2'd1,
        WARN_ORANGE = 2'd2,
        WARN_RED    = 2'd3
    } warn_t;

    localparam cfg_index_t CFG_SAMPLES_PER_POINT = 3'd0;
    localparam cfg_index_t CFG_POINT_COUNT       = 3'd1;
    localparam cfg_index_t CFG_YELLOW_THRESHOLD  = 3'd2;
    localparam cfg_index_t CFG_ORANGE_THRESHOLD  = 3'd3;
    localparam cfg_index_t CFG_RED_THRESHOLD     = 3'd4;

endpackage

@@ hw/rtl/rtsc_in_if.sv @@
`timescale 1ns / 1ps

interface rtsc_in_if;
    import rtsc_pkg::*;

    logic         valid;
    logic         ready;
    op_t          operation;
    adc_reading_t adc_reading;
    level_t       given_level;

    modport source (output valid, output operation, output adc_reading, output given_level,
                    input ready);
    modport sink (input valid, input operation, input adc_reading, input given_level,
                  output ready);
endinterface

@@ hw/rtl/rtsc_out_if.sv @@
`timescale 1ns / 1ps

interface rtsc_out_if;
    import rtsc_pkg::*;

    logic   valid;
    logic   ready;
    level_t rain_level;
    warn_t  warning_level;

    modport source (output valid, output rain_level, output warning_level, input ready);
    modport sink (input valid, input rain_level, input warning_level, output ready);
endinterface

@@ hw/rtl/rain_trend_slope_classifier_unit.sv @@
// Channel   Direction  Payload
// sample    in         operation, adc_reading, given_level
// result    out        rain_level, warning_level
//
// A sample that completes no group only adds to the group sum; a classify request goes
// straight to S_OUT. A sample that completes a point runs 10 steps of the shared
// subtractor to divide the group sum, then updates the sums through the shared multiplier.
// A sample that completes the fit then forms the products and the denominator (S_M1 to
// S_M5), runs 8 divide steps unless the denominator is zero, and loads the result in S_OUT.
// Reset clears the control state and sums at once (no clearing pass); the datapath registers are not reset.
// A result that waits on result.ready holds the sequencer only when the next one is due.
`timescale 1ns / 1ps
`include "rain_trend_slope_classifier_unit_macros.svh"

module rain_trend_slope_classifier_unit (
    input  logic                clk,
    input  logic                rst_n,
    rtsc_in_if.sink             sample,
    rtsc_out_if.source          result,
    input  logic                cfg_we,
    input  rtsc_pkg::cfg_index_t cfg_index,
    input  rtsc_pkg::cfg_data_t  cfg_data
);
    import rtsc_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_GDIV = 12'b000000000010,
        S_PT1  = 12'b000000000100,
        S_PT2  = 12'b000000001000,
        S_PT3  = 12'b000000010000,
        S_M1   = 12'b000000100000,
        S_M2   = 12'b000001000000,
        S_M3   = 12'b000010000000,
        S_M4   = 12'b000100000000,
        S_M5   = 12'b001000000000,
        S_SDIV = 12'b010000000000,
        S_OUT  = 12'b100000000000
    } state_t;

    state_t state_reg;

    logic [7:0] spp_reg, npts_reg, yellow_reg, orange_reg, red_reg;

    logic [GSUM_W-1:0] group_sum_reg;
    logic [CNT_W-1:0]  group_count_reg;
    logic [IDX_W-1:0]  point_index_reg;
    logic [SY_W-1:0]   sum_y_reg;
    logic [SXY_W-1:0]  sum_xy_reg;
    logic [SX_W-1:0]   sum_x_reg;
    logic [SX2_W-1:0]  sum_x2_reg;

    logic [PROD_W-1:0] rem_reg;
    logic [DSH_W-1:0]  dsh_reg;
    logic [QW-1:0]     quot_reg;
    logic [STEP_W-1:0] step_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] acc_reg;
    level_t            level_reg;

    logic   out_valid_reg;
    level_t out_level_reg;
    warn_t  out_warn_reg;

    logic [ADC_BITS-1:0] inverted;
    logic [GSUM_W-1:0]   group_sum_acc;
    logic [CNT_W:0]      count_inc;
    logic [7:0]          spp_eff, npts_eff;
    logic                group_done;
    logic [IDX_W:0]      index_inc;

    logic [DSH_W:0]    trial;
    logic              take;
    logic [PROD_W-1:0] rem_step;
    logic [QW-1:0]     quot_step;
    level_t            slope_level;

    logic [MA_W-1:0]      mul_a;
    logic [MB_W-1:0]      mul_b;
    logic [MA_W+MB_W-1:0] mul_full;

    logic [PROD_W:0]   num_diff, num_neg;
    logic [PROD_W-1:0] num_mag;
    logic [PROD_W-1:0] den_full;
    logic [DEN_W-1:0]  den;
    logic              load_out;

    function automatic warn_t grade(level_t lvl, logic [7:0] yel, logic [7:0] ora,
                                    logic [7:0] red);
        warn_t w;
        if (lvl >= red) begin
            w = WARN_RED;
        end else if (lvl >= ora) begin
            w = WARN_ORANGE;
        end else if (lvl >= yel) begin
            w = WARN_YELLOW;
        end else begin
            w = WARN_NONE;
        end
        return w;
    endfunction

    assign inverted      = ADC_MAX - sample.adc_reading[ADC_BITS-1:0];
    assign group_sum_acc = group_sum_reg + GSUM_W'(inverted);
    assign count_inc     = {1'b0, group_count_reg} + (CNT_W+1)'(1);
    assign spp_eff       = (spp_reg == 8'd0) ? 8'd1 : spp_reg;
    assign npts_eff      = (npts_reg == 8'd0) ? 8'd1 : npts_reg;
    assign group_done    = count_inc >= {1'b0, spp_eff};
    assign index_inc     = {1'b0, point_index_reg} + (IDX_W+1)'(1);

    // One restoring divide step on the shared subtractor.
    assign trial     = {(DSH_W+1-PROD_W)'(0), rem_reg} - {1'b0, dsh_reg};
    assign take      = !trial[DSH_W];
    assign rem_step  = take ? trial[PROD_W-1:0] : rem_reg;
    assign quot_step = {quot_reg[QW-2:0], take};
    assign slope_level = (quot_step > QW'(LEVEL_CLAMP)) ? LEVEL_W'(LEVEL_CLAMP)
                                                        : quot_step[LEVEL_W-1:0];

    always_comb
    begin
        unique case (state_reg)
            S_PT1:
            begin
                mul_a = MA_W'(point_index_reg);
                mul_b = MB_W'(quot_reg);
            end
            S_PT2:
            begin
                mul_a = MA_W'(point_index_reg);
                mul_b = MB_W'(point_index_reg);
            end
            S_M1:
            begin
                mul_a = sum_xy_reg;
                mul_b = MB_W'(point_index_reg);
            end
            S_M2:
            begin
                mul_a = MA_W'(sum_x_reg);
                mul_b = sum_y_reg;
            end
            S_M3:
            begin
                mul_a = MA_W'(sum_x2_reg);
                mul_b = MB_W'(point_index_reg);
            end
            S_M4:
            begin
                mul_a = MA_W'(sum_x_reg);
                mul_b = MB_W'(sum_x_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    assign num_diff = {1'b0, acc_reg} - {1'b0, prod_reg};
    assign num_neg  = (PROD_W+1)'(0) - num_diff;
    assign num_mag  = num_diff[PROD_W] ? num_neg[PROD_W-1:0] : num_diff[PROD_W-1:0];
    assign den_full = acc_reg - prod_reg;
    assign den      = den_full[DEN_W-1:0];

    assign load_out = (state_reg == S_OUT) && (!out_valid_reg || result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            spp_reg    <= SPP_RESET;
            npts_reg   <= NPTS_RESET;
            yellow_reg <= YELLOW_RESET;
            orange_reg <= ORANGE_RESET;
            red_reg    <= RED_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_SAMPLES_PER_POINT: spp_reg    <= cfg_data;
                CFG_POINT_COUNT:       npts_reg   <= cfg_data;
                CFG_YELLOW_THRESHOLD:  yellow_reg <= cfg_data;
                CFG_ORANGE_THRESHOLD:  orange_reg <= cfg_data;
                CFG_RED_THRESHOLD:     red_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg       <= S_IDLE;
            group_sum_reg   <= '0;
            group_count_reg <= '0;
            point_index_reg <= '0;
            sum_y_reg       <= '0;
            sum_xy_reg      <= '0;
            sum_x_reg       <= '0;
            sum_x2_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (result.ready) begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (sample.valid) begin
                        if (sample.operation == OP_CLASSIFY) begin
                            state_reg <= S_OUT;
                        end else if (group_done) begin
                            group_sum_reg   <= '0;
                            group_count_reg <= '0;
                            state_reg       <= S_GDIV;
                        end else begin
                            group_sum_reg   <= group_sum_acc;
                            group_count_reg <= count_inc[CNT_W-1:0];
                        end
                    end
                end
                S_GDIV:
                begin
                    if (step_reg == '0) begin
                        state_reg <= S_PT1;
                    end
                end
                S_PT1:
                begin
                    state_reg <= S_PT2;
                end
                S_PT2:
                begin
                    sum_xy_reg <= sum_xy_reg + prod_reg[SXY_W-1:0];
                    sum_y_reg  <= sum_y_reg + SY_W'(quot_reg);
                    sum_x_reg  <= sum_x_reg + SX_W'(point_index_reg);
                    state_reg  <= S_PT3;
                end
                S_PT3:
                begin
                    sum_x2_reg      <= sum_x2_reg + prod_reg[SX2_W-1:0];
                    point_index_reg <= index_inc[IDX_W-1:0];
                    if (index_inc >= {1'b0, npts_eff}) begin
                        state_reg <= S_M1;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_M1:
                begin
                    state_reg <= S_M2;
                end
                S_M2:
                begin
                    state_reg <= S_M3;
                end
                S_M3:
                begin
                    state_reg <= S_M4;
                end
                S_M4:
                begin
                    state_reg <= S_M5;
                end
                S_M5:
                begin
                    point_index_reg <= '0;
                    sum_y_reg       <= '0;
                    sum_xy_reg      <= '0;
                    sum_x_reg       <= '0;
                    sum_x2_reg      <= '0;
                    if (den == '0) begin
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_SDIV;
                    end
                end
                S_SDIV:
                begin
                    if (step_reg == '0) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (load_out) begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_full[PROD_W-1:0];

        unique case (state_reg) inside
            S_IDLE:
            begin
                if (sample.valid) begin
                    level_reg <= sample.given_level;
                    rem_reg   <= PROD_W'(group_sum_acc);
                    dsh_reg   <= DSH_W'(count_inc[CNT_W-1:0]) << (QW - 1);
                    quot_reg  <= '0;
                    step_reg  <= STEP_W'(QW - 1);
                end
            end
            S_GDIV, S_SDIV:
            begin
                rem_reg  <= rem_step;
                dsh_reg  <= dsh_reg >> 1;
                quot_reg <= quot_step;
                step_reg <= step_reg - STEP_W'(1);
                if (state_reg == S_SDIV) begin
                    level_reg <= slope_level;
                end
            end
            S_M2, S_M4:
            begin
                acc_reg <= prod_reg;
            end
            S_M3:
            begin
                rem_reg <= num_mag;
            end
            S_M5:
            begin
                level_reg <= '0;
                dsh_reg   <= DSH_W'(den) << (SLOPE_STEPS - 1);
                quot_reg  <= '0;
                step_reg  <= STEP_W'(SLOPE_STEPS - 1);
            end
            default:
            begin
            end
        endcase

        if (load_out) begin
            out_level_reg <= level_reg;
            out_warn_reg  <= grade(level_reg, yellow_reg, orange_reg, red_reg);
        end
    end

    assign sample.ready         = (state_reg == S_IDLE);
    assign result.valid         = out_valid_reg;
    assign result.rain_level    = out_level_reg;
    assign result.warning_level = out_warn_reg;

    `RTSC_ASSERT_NEXT(a_out_wait, state_reg == S_OUT && out_valid_reg && !result.ready, state_reg == S_OUT, "result overwritten while still waiting")
    `RTSC_ASSERT_NEXT(a_fit_cleared, state_reg == S_M5, point_index_reg == '0 && sum_y_reg == '0 && sum_x_reg == '0, "fit sums not cleared after the slope")
    `RTSC_ASSERT_NEXT(a_slope_clamped, state_reg == S_SDIV && step_reg == '0, level_reg <= LEVEL_W'(LEVEL_CLAMP), "slope level above the clamp")
    `RTSC_ASSERT_IMP(a_out_source, $rose(out_valid_reg), $past(state_reg) == S_OUT, "result raised outside the output state")

endmodule
